// File: design/swm_pkg.sv
package swm_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_WIDTH = 32;

  localparam int WIN_W  = 7;
  localparam int POS_W  = 7;
  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int OCC_W  = $clog2(WINDOW_MAX + 1);
  localparam int ENTRY_W = SAMPLE_WIDTH + POS_W;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start;
    logic [WIN_W-1:0]               win;
  } swm_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_FRONT,
    ST_OUT
  } swm_state_e;

  function automatic slot_t prev_slot(slot_t s);
    slot_t r;
    if (s == '0) begin
      r = SLOT_W'(WINDOW_MAX - 1);
    end else begin
      r = s - SLOT_W'(1);
    end
    return r;
  endfunction

  function automatic slot_t next_slot(slot_t s);
    slot_t r;
    if (32'(s) + 1 >= WINDOW_MAX) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

// File: design/swm_ram.sv
module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/swm_front.sv
module swm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  swm_pkg::sample_t               sample_i,
  input  logic                           start_of_array_i,
  input  logic [swm_pkg::WIN_W-1:0]      window_size_i,
  output logic                           item_valid_o,
  output swm_pkg::swm_item_t             item_o,
  input  logic                           item_pop_i
);
  import swm_pkg::*;

  swm_item_t        buf_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;
  logic [WIN_W-1:0] win_eff;

  // zero means one, above the deque depth means the depth
  always_comb begin
    if (window_size_i == '0) begin
      win_eff = WIN_W'(1);
    end else if (32'(window_size_i) > WINDOW_MAX) begin
      win_eff = WIN_W'(WINDOW_MAX);
    end else begin
      win_eff = window_size_i;
    end
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= '{sample: sample_i, start: start_of_array_i, win: win_eff};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: design/swm_back.sv
module swm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  swm_pkg::swm_item_t item_i,
  output logic               item_pop_o,
  output swm_pkg::sample_t   window_max_o,
  output logic               empty_o,
  input  logic               pop_i
);
  import swm_pkg::*;

  swm_state_e       state_q, state_d;
  slot_t            head_q, head_d;
  slot_t            tail_q, tail_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] seen_q, seen_d;
  swm_item_t        cur_q, cur_d;
  logic             use_new_q, use_new_d;
  logic             emit_q, emit_d;

  logic             ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic             back_re, head_re;
  logic [ENTRY_W-1:0] back_rdata, head_rdata;
  slot_t            back_raddr;
  sample_t          back_val, head_val;
  logic [POS_W-1:0] head_pos;
  logic             cmp_pop;

  sample_t          out_data_q [2];
  logic             out_wr_q, out_rd_q;
  logic [1:0]       out_cnt_q;
  logic             out_push, out_pop, out_full;

  assign back_val   = $signed(back_rdata[ENTRY_W-1:POS_W]);
  assign head_val   = $signed(head_rdata[ENTRY_W-1:POS_W]);
  assign head_pos   = head_rdata[POS_W-1:0];
  assign back_raddr = prev_slot(tail_d);
  assign out_full   = (out_cnt_q == 2'd2);
  assign cmp_pop    = (occ_q != '0) && (back_val < cur_q.sample);

  swm_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_MAX)) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (back_re),
    .raddr_i (back_raddr),
    .rdata_o (back_rdata)
  );

  swm_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_MAX)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (head_re),
    .raddr_i (head_d),
    .rdata_o (head_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!cmp_pop) begin
          state_d = ST_FRONT;
        end
      end
      ST_FRONT: state_d = ST_OUT;
      ST_OUT: begin
        if (!emit_q || !out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [POS_W-1:0] age;
    logic [POS_W-1:0] seen_n;
    slot_t            h;
    logic [OCC_W-1:0] o;
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    pos_d      = pos_q;
    seen_d     = seen_q;
    cur_d      = cur_q;
    use_new_d  = use_new_q;
    emit_d     = emit_q;
    item_pop_o = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = {cur_q.sample, pos_q};
    back_re    = 1'b0;
    head_re    = 1'b0;
    out_push   = 1'b0;
    age        = pos_q - head_pos;
    seen_n     = seen_q;
    h          = head_q;
    o          = occ_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          if (item_i.start) begin
            head_d = '0;
            tail_d = '0;
            occ_d  = '0;
            pos_d  = '0;
            seen_d = '0;
          end
          back_re = 1'b1;
          head_re = 1'b1;
        end
      end
      ST_CMP: begin
        // drop smaller entries from the back, one per cycle
        if (cmp_pop) begin
          tail_d  = prev_slot(tail_q);
          occ_d   = occ_q - OCC_W'(1);
          back_re = 1'b1;
        end
      end
      ST_FRONT: begin
        if ((o != '0) && (age >= cur_q.win)) begin
          h = next_slot(h);
          o = o - OCC_W'(1);
        end
        if (o >= OCC_W'(WINDOW_MAX)) begin
          h = next_slot(h);
          o = o - OCC_W'(1);
        end
        use_new_d = (o == '0);
        head_d    = h;
        head_re   = 1'b1;
        ram_we    = 1'b1;
        tail_d    = next_slot(tail_q);
        occ_d     = o + OCC_W'(1);
        pos_d     = pos_q + POS_W'(1);
        seen_n    = (seen_q != '1) ? seen_q + POS_W'(1) : seen_q;
        seen_d    = seen_n;
        emit_d    = (seen_n >= cur_q.win);
      end
      ST_OUT: begin
        if (emit_q && !out_full) begin
          out_push = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      occ_q     <= '0;
      pos_q     <= '0;
      seen_q    <= '0;
      use_new_q <= 1'b0;
      emit_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      occ_q     <= occ_d;
      pos_q     <= pos_d;
      seen_q    <= seen_d;
      use_new_q <= use_new_d;
      emit_q    <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // result queue
  assign out_pop      = pop_i && (out_cnt_q != 2'd0);
  assign empty_o      = (out_cnt_q == 2'd0);
  assign window_max_o = out_data_q[out_rd_q];

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_data_q[out_wr_q] <= use_new_q ? cur_q.sample : head_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (out_push) begin
        out_wr_q <= !out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= !out_rd_q;
      end
      out_cnt_q <= out_cnt_q + 2'(out_push) - 2'(out_pop);
    end
  end

endmodule

// File: design/sliding_window_max.sv
// channel   direction  handshake                   word
// sample    in         push_i / full_o             sample_i, start_of_array_i
// result    out        pop_i / empty_o             window_max_o
// config    in         cfg_valid_i / cfg_ready_o   cfg_window_size_i
//
// each sample passes idle, compare, front and out in the deque engine, repeating compare
// per entry dropped from the back; the back-compare loop reads one deque entry per cycle from ram
// two-entry queues on input and result side let either side stall on its own
// reset clears the deque, counters and queues; window_size resets to 1
// a start_of_array word clears the deque before that sample is taken
module sliding_window_max (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  swm_pkg::sample_t          sample_i,
  input  logic                      start_of_array_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output swm_pkg::sample_t          window_max_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [swm_pkg::WIN_W-1:0] cfg_window_size_i
);
  import swm_pkg::*;

  logic [WIN_W-1:0] window_size_q;
  logic             item_valid;
  logic             item_pop;
  swm_item_t        item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WIN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_size_q <= cfg_window_size_i;
    end
  end

  swm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_o           (full_o),
    .sample_i         (sample_i),
    .start_of_array_i (start_of_array_i),
    .window_size_i    (window_size_q),
    .item_valid_o     (item_valid),
    .item_o           (item),
    .item_pop_i       (item_pop)
  );

  swm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .window_max_o (window_max_o),
    .empty_o      (empty_o),
    .pop_i        (pop_i)
  );

endmodule
